@@ sv/dshot_frame_transmitter_unit_defines.svh @@
// Assertion macros for the DShot frame transmitter unit
`ifndef DSHOT_FRAME_TRANSMITTER_UNIT_DEFINES_SVH
`define DSHOT_FRAME_TRANSMITTER_UNIT_DEFINES_SVH

// check a property on every clock edge outside reset
`define DFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that an antecedent is followed by a consequent in the next cycle
`define DFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dft_pkg.sv @@
// Shared types, constants and frame builder for the DShot frame transmitter
package dft_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int FRAME_BITS = 16;
  localparam int PIN_W      = 4;
  localparam int NUM_PINS   = (NUM_MOTORS < PIN_W) ? NUM_MOTORS : PIN_W;
  localparam int BIT_IDX_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 16;

  localparam logic [PIN_W-1:0] PIN_MASK = PIN_W'((1 << NUM_PINS) - 1);

  localparam logic [CFG_W-1:0] BIT_PERIOD_RST = 16'd139;
  localparam logic [CFG_W-1:0] ZERO_HIGH_RST  = 16'd52;
  localparam logic [CFG_W-1:0] ONE_HIGH_RST   = 16'd104;

  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_PERIOD = 2'd0,
    CFG_ZERO_HIGH  = 2'd1,
    CFG_ONE_HIGH   = 2'd2
  } cfg_idx_e;

  function automatic frame_t build_frame(logic [10:0] value, logic telemetry);
    logic [11:0] packet;
    logic [3:0]  csum;
    packet = {value, telemetry};
    csum   = packet[3:0] ^ packet[7:4] ^ packet[11:8];
    return {packet, csum};
  endfunction

endpackage

@@ sv/dshot_frame_transmitter_unit.sv @@
// DShot frame transmitter: pending frame store, bit timing and output register
//
// One transaction is taken per clock cycle; its result appears in the output
// register on the next cycle. A load stores a frame for one motor, an idle
// start copies all pending frames into the shift registers, and each busy tick
// advances the bit-period counter and updates the pin levels. The whole update
// is one pass of logic between input and state/result registers, so the input
// stalls only while a result is held by a stalled output. Configuration
// registers are written through a plain write port and take effect at once.
`include "dshot_frame_transmitter_unit_defines.svh"

module dshot_frame_transmitter_unit import dft_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [1:0]           motor_i,
  input  logic [10:0]          value_i,
  input  logic                 telemetry_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIN_W-1:0]     motor_pins_o,
  output logic                 busy_res_o,
  output logic                 frame_done_o
);

  logic [CFG_W-1:0]     bit_period_q, zero_high_q, one_high_q;
  frame_t               pending_q [NUM_MOTORS];
  frame_t               pending_d [NUM_MOTORS];
  frame_t               shift_q   [NUM_MOTORS];
  frame_t               shift_d   [NUM_MOTORS];
  logic [BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic [CFG_W-1:0]     tick_q, tick_d;
  logic                 sending_q, sending_d;
  logic [PIN_W-1:0]     pins_q, pins_d;
  logic                 done_q, done_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 apply;
  logic [PIN_W-1:0]     zero_pins;
  logic [PIN_W-1:0]     lvl;
  logic [BIT_IDX_W-1:0] bit_inc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign bit_inc    = bit_idx_q + BIT_IDX_W'(1);

  always_comb begin
    pending_d = pending_q;
    shift_d   = shift_q;
    bit_idx_d = bit_idx_q;
    tick_d    = tick_q;
    sending_d = sending_q;
    done_d    = 1'b0;
    apply     = 1'b0;
    case (cmd_i)
      CMD_LOAD: begin
        for (int m = 0; m < NUM_MOTORS; m++) begin
          if (32'(motor_i) == m) begin
            pending_d[m] = build_frame(value_i, telemetry_i);
          end
        end
      end
      CMD_START: begin
        if (!sending_q) begin
          for (int m = 0; m < NUM_MOTORS; m++) begin
            shift_d[m]   = pending_q[m];
            pending_d[m] = '0;
          end
          sending_d = 1'b1;
          bit_idx_d = '0;
          tick_d    = '0;
          apply     = 1'b1;
        end
      end
      CMD_TICK: begin
        if (sending_q) begin
          if (tick_q >= bit_period_q) begin
            tick_d    = '0;
            bit_idx_d = bit_inc;
            for (int m = 0; m < NUM_MOTORS; m++) begin
              shift_d[m] = {shift_q[m][FRAME_BITS-2:0], 1'b0};
            end
            if (32'(bit_inc) >= FRAME_BITS) begin
              sending_d = 1'b0;
              done_d    = 1'b1;
            end else begin
              apply = 1'b1;
            end
          end else begin
            tick_d = tick_q + CFG_W'(1);
            apply  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    zero_pins = '0;
    for (int m = 0; m < NUM_PINS; m++) begin
      zero_pins[m] = ~shift_d[m][FRAME_BITS-1];
    end
    lvl = pins_q;
    if (tick_d == '0) begin
      lvl = PIN_MASK;
    end
    if (tick_d == zero_high_q) begin
      lvl = lvl & ~zero_pins;
    end
    if (tick_d == one_high_q) begin
      lvl = '0;
    end
    if (done_d) begin
      pins_d = '0;
    end else if (apply) begin
      pins_d = lvl & PIN_MASK;
    end else begin
      pins_d = pins_q;
    end
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= BIT_PERIOD_RST;
      zero_high_q  <= ZERO_HIGH_RST;
      one_high_q   <= ONE_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BIT_PERIOD: bit_period_q <= cfg_data_i;
        CFG_ZERO_HIGH:  zero_high_q  <= cfg_data_i;
        CFG_ONE_HIGH:   one_high_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        pending_q[m] <= '0;
        shift_q[m]   <= '0;
      end
      bit_idx_q   <= '0;
      tick_q      <= '0;
      sending_q   <= 1'b0;
      pins_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        pending_q <= pending_d;
        shift_q   <= shift_d;
        bit_idx_q <= bit_idx_d;
        tick_q    <= tick_d;
        sending_q <= sending_d;
        pins_q    <= pins_d;
        done_q    <= done_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign motor_pins_o = pins_q;
  assign busy_res_o   = sending_q;
  assign frame_done_o = done_q;

  `DFT_ASSERT(a_done_idle, !(frame_done_o && busy_res_o), "frame done while still busy")
  `DFT_ASSERT(a_idle_low, busy_res_o || (motor_pins_o == '0), "pins high while idle")
  `DFT_ASSERT(a_bit_range, !sending_q || (32'(bit_idx_q) < FRAME_BITS), "bit index out of range")
  `DFT_ASSERT_NEXT(a_result, accept, out_valid_o, "accepted transaction gave no result")

endmodule
